// File: src/crse_pkg.sv
// Package for the Catmull-Rom spline evaluator: mode codes, field widths and
// the default fixed-point format. No dependencies.
package crse_pkg;

	// Control values and results are signed 32-bit fixed point.
	localparam int DATA_W = 32;
	// Widest spline coefficient (2C or 3D) needs 37 bits; one spare bit.
	localparam int COEF_W = 38;
	// Base term plus three rounded products.
	localparam int SUM_W = COEF_W + 2;
	// Default number of fractional bits.
	localparam int FRAC_BITS_DEF = 16;

	// Mode codes carried in func.
	localparam logic [2:0] MODE_POS        = 3'd0;
	localparam logic [2:0] MODE_START_POS  = 3'd1;
	localparam logic [2:0] MODE_END_POS    = 3'd2;
	localparam logic [2:0] MODE_DERIV      = 3'd3;
	localparam logic [2:0] MODE_START_DERV = 3'd4;
	localparam logic [2:0] MODE_END_DERV   = 3'd5;

endpackage

// File: src/catmull_rom_spline_eval_core.sv
// Catmull-Rom spline evaluator core: four-stage pipeline computing one
// position or derivative coordinate per request. Depends on crse_pkg.
//
// Channel   Direction  Handshake             Payload
// request   in         in_valid / in_ready   func, p0, p1, p2, p3, t_frac
// result    out        out_valid / out_ready value, saturated, bad_mode
//
// A request passes the stage 1, 2 and 3 registers and then the stage 4 output register.
// One request is taken every cycle unless the output register is held; the four pipeline
// stages are t powers and coefficients, first products, third product and final sum.
// Reset clears the stage valid bits only; no clearing pass is needed.
// When the output register holds a result that is not taken, all stages hold.
module catmull_rom_spline_eval_core #(
	parameter int FRAC_BITS = crse_pkg::FRAC_BITS_DEF
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   in_valid,
	output logic                                   in_ready,
	input  logic [2:0]                             func,
	input  logic signed [crse_pkg::DATA_W-1:0]     p0,
	input  logic signed [crse_pkg::DATA_W-1:0]     p1,
	input  logic signed [crse_pkg::DATA_W-1:0]     p2,
	input  logic signed [crse_pkg::DATA_W-1:0]     p3,
	input  logic [FRAC_BITS:0]                     t_frac,
	output logic                                   out_valid,
	input  logic                                   out_ready,
	output logic signed [crse_pkg::DATA_W-1:0]     value,
	output logic                                   saturated,
	output logic                                   bad_mode
);

	localparam int T_W  = FRAC_BITS + 1;
	localparam int CW   = crse_pkg::COEF_W;
	localparam int SW   = crse_pkg::SUM_W;
	localparam int DW   = crse_pkg::DATA_W;
	localparam int PW   = CW + T_W + 1;
	localparam int TT_W = 2 * T_W;
	localparam logic [T_W-1:0]  T_ONE   = T_W'(1) << FRAC_BITS;
	localparam logic [TT_W-1:0] TT_HALF = TT_W'(1) << (FRAC_BITS - 1);

	// Signed coefficient times unsigned t power, rounded half up.
	function automatic logic signed [CW-1:0] rnd_mul(
		input logic signed [CW-1:0] k,
		input logic [T_W-1:0]       t
	);
		logic signed [PW-1:0] pr;
		pr = PW'(k) * $signed(PW'(t));
		pr = pr + (PW'(1) <<< (FRAC_BITS - 1));
		return CW'(pr >>> FRAC_BITS);
	endfunction

	// Unsigned t power product, rounded half up.
	function automatic logic [T_W-1:0] rnd_tt(
		input logic [T_W-1:0] a,
		input logic [T_W-1:0] b
	);
		logic [TT_W-1:0] pr;
		pr = TT_W'(a) * TT_W'(b);
		pr = pr + TT_HALF;
		return T_W'(pr >> FRAC_BITS);
	endfunction

	// Whole pipeline advances unless the output register is held.
	logic adv;
	assign adv      = !out_valid || out_ready;
	assign in_ready = adv;

	// Stage 1: clamp t, square it, form the spline coefficients per mode.
	logic [T_W-1:0]       t_c;
	logic signed [CW-1:0] p0e, p1e, p2e, p3e;
	logic signed [CW-1:0] cb, cc, cd, cbs, ccs;
	logic signed [CW-1:0] base_d, k1_d, k2_d, k3_d;
	logic                 bad_d;

	assign t_c = (t_frac > T_ONE) ? T_ONE : t_frac;
	assign p0e = CW'(p0);
	assign p1e = CW'(p1);
	assign p2e = CW'(p2);
	assign p3e = CW'(p3);
	assign cb  = p2e - p0e;
	assign cc  = (p0e <<< 1) - ((p1e <<< 2) + p1e) + (p2e <<< 2) - p3e;
	assign cd  = p3e - p0e + ((p1e <<< 1) + p1e) - ((p2e <<< 1) + p2e);
	assign cbs = (p1e <<< 2) - ((p0e <<< 1) + p0e) - p2e;
	assign ccs = p0e - (p1e <<< 1) + p2e;

	always_comb begin
		base_d = '0;
		k1_d   = '0;
		k2_d   = '0;
		k3_d   = '0;
		bad_d  = 1'b0;
		case (func)
			crse_pkg::MODE_POS: begin
				base_d = p1e <<< 1;
				k1_d   = cb;
				k2_d   = cc;
				k3_d   = cd;
			end
			crse_pkg::MODE_START_POS: begin
				base_d = p0e <<< 1;
				k1_d   = cbs;
				k2_d   = ccs;
			end
			crse_pkg::MODE_END_POS: begin
				base_d = p1e <<< 1;
				k1_d   = cb;
				k2_d   = ccs;
			end
			crse_pkg::MODE_DERIV: begin
				base_d = cb;
				k1_d   = cc <<< 1;
				k2_d   = (cd <<< 1) + cd;
			end
			crse_pkg::MODE_START_DERV: begin
				base_d = cbs;
				k1_d   = ccs <<< 1;
			end
			crse_pkg::MODE_END_DERV: begin
				base_d = cb;
				k1_d   = ccs <<< 1;
			end
			default: begin
				bad_d = 1'b1;
			end
		endcase
	end

	logic                 valid_s1;
	logic [T_W-1:0]       t_s1, t2_s1;
	logic signed [CW-1:0] base_s1, k1_s1, k2_s1, k3_s1;
	logic                 bad_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t_s1    <= t_c;
			t2_s1   <= rnd_tt(t_c, t_c);
			base_s1 <= base_d;
			k1_s1   <= k1_d;
			k2_s1   <= k2_d;
			k3_s1   <= k3_d;
			bad_s1  <= bad_d;
		end
	end

	// Stage 2: cube of t and the first two rounded products.
	logic                 valid_s2;
	logic [T_W-1:0]       t3_s2;
	logic signed [CW-1:0] r1_s2, r2_s2, base_s2, k3_s2;
	logic                 bad_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			t3_s2   <= rnd_tt(t2_s1, t_s1);
			r1_s2   <= rnd_mul(k1_s1, t_s1);
			r2_s2   <= rnd_mul(k2_s1, t2_s1);
			base_s2 <= base_s1;
			k3_s2   <= k3_s1;
			bad_s2  <= bad_s1;
		end
	end

	// Stage 3: third rounded product and the partial sum.
	logic                 valid_s3;
	logic signed [CW-1:0] r3_s3;
	logic signed [SW-1:0] acc_s3;
	logic                 bad_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (adv) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			r3_s3  <= rnd_mul(k3_s2, t3_s2);
			acc_s3 <= SW'(base_s2) + SW'(r1_s2) + SW'(r2_s2);
			bad_s3 <= bad_s2;
		end
	end

	// Stage 4: final sum, halving rounded half up, saturation.
	logic signed [SW-1:0] sum_d, half_d;
	logic                 ovf_d;
	logic signed [DW-1:0] val_d;

	assign sum_d  = acc_s3 + SW'(r3_s3);
	assign half_d = (sum_d + SW'(1)) >>> 1;
	assign ovf_d  = (half_d[SW-1:DW-1] != '0) && (half_d[SW-1:DW-1] != '1);

	always_comb begin
		if (ovf_d) begin
			val_d = half_d[SW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
		end else begin
			val_d = half_d[DW-1:0];
		end
	end

	logic                 valid_s4;
	logic signed [DW-1:0] value_s4;
	logic                 sat_s4;
	logic                 bad_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (adv) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			value_s4 <= bad_s3 ? '0 : val_d;
			sat_s4   <= !bad_s3 && ovf_d;
			bad_s4   <= bad_s3;
		end
	end

	assign out_valid = valid_s4;
	assign value     = value_s4;
	assign saturated = sat_s4;
	assign bad_mode  = bad_s4;

`ifndef NO_ASSERTIONS
	// An unused mode yields a zero, unclipped result.
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && bad_mode |-> value == '0 && !saturated)
		else $error("bad mode result is not zero");

	// A clipped result sits exactly on one of the two bounds.
	a_sat_bound: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && saturated |->
		value == {1'b0, {(DW-1){1'b1}}} || value == {1'b1, {(DW-1){1'b0}}})
		else $error("saturated value is not at a bound");

	// A stalled pipeline keeps the request in the first stage.
	a_s1_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !adv |=> valid_s1)
		else $error("first stage lost a request during a stall");

	// A stalled pipeline keeps the request in the third stage.
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && !adv |=> valid_s3 && $stable(acc_s3))
		else $error("third stage changed during a stall");
`endif

endmodule
